[rtl/core/ssml_pkg.sv]
// Shared constants, types and the control program of the speed sensor mismatch logger.
package ssml_pkg;

	localparam int SAMPLE_DEPTH = 60;
	localparam int IDX_W = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(SAMPLE_DEPTH + 1);
	localparam int STEP_W = 16;
	localparam int PROD_W = 18;

	localparam int IN_DATA_W = 56;
	localparam int IN_USER_W = 2;
	localparam int OUT_DATA_W = 88;
	localparam int OUT_USER_W = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MIN_REF = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PER_MILLE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TICKS = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd3;

	localparam logic [7:0] MIN_REF_RST = 8'd40;
	localparam logic [9:0] PER_MILLE_RST = 10'd110;
	localparam logic [15:0] TICKS_RST = 16'd20;
	localparam logic [15:0] WINDOW_RST = 16'd300;
	localparam logic [PROD_W-1:0] MILLE = 18'd1000;

	// datapath operations
	localparam int OP_W = 3;
	localparam logic [OP_W-1:0] OP_NOP = 3'd0;
	localparam logic [OP_W-1:0] OP_ACCEPT = 3'd1;
	localparam logic [OP_W-1:0] OP_PRODUCT = 3'd2;
	localparam logic [OP_W-1:0] OP_COUNT = 3'd3;
	localparam logic [OP_W-1:0] OP_SAMPLE = 3'd4;
	localparam logic [OP_W-1:0] OP_HEADER = 3'd5;
	localparam logic [OP_W-1:0] OP_READ = 3'd6;
	localparam logic [OP_W-1:0] OP_PAIR = 3'd7;

	// jump conditions
	localparam int COND_W = 4;
	localparam logic [COND_W-1:0] C_NEXT = 4'd0;
	localparam logic [COND_W-1:0] C_ALWAYS = 4'd1;
	localparam logic [COND_W-1:0] C_NO_ITEM = 4'd2;
	localparam logic [COND_W-1:0] C_SKIP = 4'd3;
	localparam logic [COND_W-1:0] C_INACTIVE = 4'd4;
	localparam logic [COND_W-1:0] C_NO_SAMPLE = 4'd5;
	localparam logic [COND_W-1:0] C_NO_EMIT = 4'd6;
	localparam logic [COND_W-1:0] C_OUT_BUSY = 4'd7;
	localparam logic [COND_W-1:0] C_MORE = 4'd8;

	localparam int PC_W = 4;
	localparam logic [PC_W-1:0] PC_IDLE = 4'd0;
	localparam logic [PC_W-1:0] PC_HEADER = 4'd5;
	localparam logic [PC_W-1:0] PC_READ = 4'd6;
	localparam logic [PC_W-1:0] PC_PAIR = 4'd7;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [COND_W-1:0] cond;
		logic [PC_W-1:0]   target;
	} ctrl_word_t;

	typedef struct packed {
		logic item_valid;
		logic skip;
		logic inactive;
		logic no_sample;
		logic no_emit;
		logic out_busy;
		logic more;
	} dp_flags_t;

	function automatic ctrl_word_t prog_rom(input logic [PC_W-1:0] pc);
		ctrl_word_t cw;
		unique case (pc)
			4'd0:    cw = '{OP_ACCEPT, C_NO_ITEM, PC_IDLE};
			4'd1:    cw = '{OP_NOP, C_SKIP, PC_IDLE};
			4'd2:    cw = '{OP_PRODUCT, C_INACTIVE, PC_IDLE};
			4'd3:    cw = '{OP_COUNT, C_NO_SAMPLE, PC_IDLE};
			4'd4:    cw = '{OP_SAMPLE, C_NO_EMIT, PC_IDLE};
			4'd5:    cw = '{OP_HEADER, C_OUT_BUSY, PC_HEADER};
			4'd6:    cw = '{OP_READ, C_NEXT, PC_IDLE};
			4'd7:    cw = '{OP_PAIR, C_OUT_BUSY, PC_PAIR};
			4'd8:    cw = '{OP_NOP, C_MORE, PC_READ};
			4'd9:    cw = '{OP_NOP, C_ALWAYS, PC_IDLE};
			default: cw = '{OP_NOP, C_ALWAYS, PC_IDLE};
		endcase
		return cw;
	endfunction

endpackage

[rtl/core/ssml_seq.sv]
// Step counter, control store and jump logic.
module ssml_seq (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ssml_pkg::dp_flags_t    flags,
	output ssml_pkg::ctrl_word_t   cw
);
	import ssml_pkg::*;

	logic [PC_W-1:0] pc_q;
	logic            jump;

	assign cw = prog_rom(pc_q);

	always_comb begin
		case (cw.cond)
			C_NEXT:      jump = 1'b0;
			C_ALWAYS:    jump = 1'b1;
			C_NO_ITEM:   jump = !flags.item_valid;
			C_SKIP:      jump = flags.skip;
			C_INACTIVE:  jump = flags.inactive;
			C_NO_SAMPLE: jump = flags.no_sample;
			C_NO_EMIT:   jump = flags.no_emit;
			C_OUT_BUSY:  jump = flags.out_busy;
			C_MORE:      jump = flags.more;
			default:     jump = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_IDLE;
		end else if (jump) begin
			pc_q <= cw.target;
		end else begin
			pc_q <= pc_q + 1'b1;
		end
	end

endmodule

[rtl/core/ssml_dp.sv]
// Datapath: settings, tick and sample counters, sample stores and output register.
module ssml_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ssml_pkg::ctrl_word_t                cw,
	output ssml_pkg::dp_flags_t                 flags,
	input  logic                                cfg_valid,
	input  logic [ssml_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ssml_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [ssml_pkg::IN_DATA_W-1:0]      s_tdata,
	input  logic [ssml_pkg::IN_USER_W-1:0]      s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [ssml_pkg::OUT_DATA_W-1:0]     m_tdata,
	output logic [ssml_pkg::OUT_USER_W-1:0]     m_tuser,
	output logic                                m_tlast
);
	import ssml_pkg::*;

	logic [7:0]  min_ref_q;
	logic [9:0]  per_mille_q;
	logic [15:0] ticks_q;
	logic [15:0] window_q;

	logic        tv_q, nav_q;
	logic [7:0]  ref_q, wheel_q;
	logic [4:0]  day_q;
	logic [31:0] now_q;

	logic [STEP_W-1:0] bad_tick_q, good_tick_q, bad_step_q, good_step_q;
	logic [4:0]        logged_day_q;
	logic              kind_q;
	logic [PROD_W-1:0] prod_diff_q, prod_lim_q;
	logic [CNT_W-1:0]  k_q;
	logic [15:0]       rd_q;

	logic [15:0]             bad_mem [SAMPLE_DEPTH];
	logic [15:0]             good_mem [SAMPLE_DEPTH];
	logic [SAMPLE_DEPTH-1:0] bad_vld_q, good_vld_q;

	logic                m_valid_q;
	logic [OUT_DATA_W-1:0] m_data_q;
	logic [OUT_USER_W-1:0] m_user_q;
	logic                m_last_q;

	logic              accept;
	logic              skip, inactive, mismatch, take, emit, wr_en, out_busy, out_load;
	logic [7:0]        diff;
	logic [STEP_W-1:0] tick_sel, step_sel;
	logic [STEP_W:0]   tick_inc, step_inc;
	logic [IDX_W-1:0]  wr_idx, rd_idx;

	assign s_tready = (cw.op == OP_ACCEPT);
	assign accept   = s_tvalid && s_tready;

	assign skip     = !tv_q || ((logged_day_q != 5'd0) && (logged_day_q == day_q));
	assign inactive = !nav_q || (ref_q < min_ref_q);
	assign diff     = (wheel_q >= ref_q) ? (wheel_q - ref_q) : (ref_q - wheel_q);
	assign mismatch = prod_diff_q > prod_lim_q;

	assign tick_sel = mismatch ? bad_tick_q : good_tick_q;
	assign tick_inc = {1'b0, tick_sel} + 17'd1;
	assign take     = tick_inc > {1'b0, ticks_q};

	assign step_sel = kind_q ? bad_step_q : good_step_q;
	assign step_inc = {1'b0, step_sel} + 17'd1;
	assign emit     = step_inc >= {1'b0, window_q};
	assign wr_en    = (cw.op == OP_SAMPLE) && (step_sel < STEP_W'(SAMPLE_DEPTH));
	assign wr_idx   = step_sel[IDX_W-1:0];
	assign rd_idx   = k_q[IDX_W-1:0];

	assign out_busy = m_valid_q && !m_tready;
	assign out_load = ((cw.op == OP_HEADER) || (cw.op == OP_PAIR)) && !out_busy;

	assign flags = '{
		item_valid: s_tvalid,
		skip:       skip,
		inactive:   inactive,
		no_sample:  !take,
		no_emit:    !emit,
		out_busy:   out_busy,
		more:       (k_q != CNT_W'(SAMPLE_DEPTH))
	};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_ref_q   <= MIN_REF_RST;
			per_mille_q <= PER_MILLE_RST;
			ticks_q     <= TICKS_RST;
			window_q    <= WINDOW_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MIN_REF:   min_ref_q   <= cfg_data[7:0];
				REG_PER_MILLE: per_mille_q <= cfg_data[9:0];
				REG_TICKS:     ticks_q     <= cfg_data;
				REG_WINDOW:    window_q    <= cfg_data;
				default:       ;
			endcase
		end
	end

	// latched item, products and store read
	always_ff @(posedge clk) begin
		if (accept) begin
			tv_q    <= s_tuser[0];
			nav_q   <= s_tuser[1];
			ref_q   <= s_tdata[7:0];
			wheel_q <= s_tdata[15:8];
			day_q   <= s_tdata[20:16];
			now_q   <= s_tdata[52:21];
		end
		if (cw.op == OP_PRODUCT) begin
			prod_diff_q <= PROD_W'(diff) * MILLE;
			prod_lim_q  <= PROD_W'(per_mille_q) * PROD_W'(ref_q);
		end
		if (cw.op == OP_READ) begin
			if (kind_q) begin
				rd_q <= bad_vld_q[rd_idx] ? bad_mem[rd_idx] : 16'd0;
			end else begin
				rd_q <= good_vld_q[rd_idx] ? good_mem[rd_idx] : 16'd0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && kind_q) begin
			bad_mem[wr_idx] <= {wheel_q, ref_q};
		end
		if (wr_en && !kind_q) begin
			good_mem[wr_idx] <= {wheel_q, ref_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bad_tick_q   <= '0;
			good_tick_q  <= '0;
			bad_step_q   <= '0;
			good_step_q  <= '0;
			logged_day_q <= '0;
			kind_q       <= 1'b0;
			k_q          <= '0;
			bad_vld_q    <= '0;
			good_vld_q   <= '0;
		end else begin
			case (cw.op)
				OP_PRODUCT: begin
					if (inactive) begin
						bad_tick_q  <= '0;
						good_tick_q <= '0;
						bad_step_q  <= '0;
						good_step_q <= '0;
					end
				end
				OP_COUNT: begin
					kind_q <= mismatch;
					if (mismatch) begin
						good_tick_q <= '0;
						good_step_q <= '0;
						bad_tick_q  <= take ? '0 : tick_inc[STEP_W-1:0];
					end else begin
						bad_tick_q  <= '0;
						bad_step_q  <= '0;
						good_tick_q <= take ? '0 : tick_inc[STEP_W-1:0];
					end
				end
				OP_SAMPLE: begin
					// restart the step at one after a record
					if (kind_q) begin
						bad_step_q <= emit ? STEP_W'(1) : step_inc[STEP_W-1:0];
					end else begin
						good_step_q <= emit ? STEP_W'(1) : step_inc[STEP_W-1:0];
					end
					if (wr_en && kind_q) begin
						bad_vld_q[wr_idx] <= 1'b1;
					end
					if (wr_en && !kind_q) begin
						good_vld_q[wr_idx] <= 1'b1;
					end
					if (emit) begin
						logged_day_q <= day_q;
						k_q          <= '0;
					end
				end
				OP_PAIR: begin
					if (out_load) begin
						k_q <= k_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (cw.op == OP_HEADER) begin
				m_user_q <= {kind_q, 1'b0};
				m_data_q <= {24'd0, now_q, now_q - {16'd0, window_q}};
				m_last_q <= 1'b0;
			end else begin
				m_user_q <= {kind_q, 1'b1};
				m_data_q <= {2'd0, rd_q[7:0], rd_q[15:8], 6'(k_q), 64'd0};
				m_last_q <= (k_q == CNT_W'(SAMPLE_DEPTH - 1));
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;
	assign m_tlast  = m_last_q;

	a_pair_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && (cw.op == OP_PAIR)) |-> (k_q < CNT_W'(SAMPLE_DEPTH)))
		else $error("pair index beyond sample store");

	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		((bad_tick_q != '0) || (bad_step_q != '0)) |->
		((good_tick_q == '0) && (good_step_q == '0)))
		else $error("both kinds counting at once");

	a_last_on_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> m_tuser[0])
		else $error("last flag on a header item");

	a_load_after_sample: assert property (@(posedge clk) disable iff (!arst_n)
		((cw.op == OP_SAMPLE) && emit) |=> (cw.op == OP_HEADER))
		else $error("record emission did not start with a header");

endmodule

[rtl/core/speed_sensor_mismatch_logger.sv]
// Top level of the speed sensor mismatch logger: sequencer and datapath.
//
//  channel   direction  handshake            payload
//  s_*       in         s_tvalid/s_tready    tick item (speeds, day, clock)
//  m_*       out        m_tvalid/m_tready    header item, then 60 sample pairs
//  cfg_*     in         cfg_valid/cfg_ready  register index and write data
//
// A tick runs the accept, skip, product, count and sample steps, ending early on a failed
// test, one control word per cycle unless stalled. A tick that completes a window adds a
// header step, a store read, output load and loop test per stored pair, and a return step.
// The output register holds each item until taken; a stall holds the step counter.
// arst_n clears counters, stored-pair valid bits and the logged day, and resets settings.
// cfg_ready is always high.
module speed_sensor_mismatch_logger (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// [7:0] ref_speed, [15:8] wheel_speed, [20:16] day_of_month, [52:21] now_seconds
	input  logic [ssml_pkg::IN_DATA_W-1:0]      s_tdata,
	// [0] time_valid, [1] nav_fix
	input  logic [ssml_pkg::IN_USER_W-1:0]      s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [31:0] start_seconds, [63:32] end_seconds, [69:64] sample_index,
	// [77:70] wheel_sample, [85:78] ref_sample
	output logic [ssml_pkg::OUT_DATA_W-1:0]     m_tdata,
	// [0] item_kind, [1] record_status
	output logic [ssml_pkg::OUT_USER_W-1:0]     m_tuser,
	output logic                                m_tlast,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ssml_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ssml_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import ssml_pkg::*;

	ctrl_word_t cw;
	dp_flags_t  flags;

	assign cfg_ready = 1'b1;

	ssml_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.cw     (cw)
	);

	ssml_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cw        (cw),
		.flags     (flags),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule
